// ----- rtl/i64da_pkg.sv -----
// ----------------------------------------------------------------------------
// i64da_pkg
// Shared types and constants for the signed 64-bit to decimal text converter.
// ----------------------------------------------------------------------------
package i64da_pkg;

	// Width of the binary operand.
	localparam int unsigned BinWidth   = 64;
	// Decimal digits held by the BCD register (enough for 2^64 - 1).
	localparam int unsigned NumDigits  = 20;
	localparam int unsigned BcdWidth   = 4 * NumDigits;
	localparam int unsigned CntWidth   = $clog2(BinWidth);
	localparam int unsigned RemWidth   = $clog2(NumDigits + 1);
	localparam int unsigned CharWidth  = 6;

	// Character codes.
	localparam logic [CharWidth-1:0] DigitBase = 6'd48;
	localparam logic [CharWidth-1:0] MinusCode = 6'd45;

	// Operation requested from the shift unit for the current cycle.
	typedef struct packed {
		logic load;
		logic dabble;
		logic digit_shift;
	} i64da_op_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} i64da_state_t;

endpackage

// ----- rtl/int64_to_decimal_ascii_unit.sv -----
// Converts one signed 64-bit integer per request into decimal ASCII text.
// After acceptance, the shared shift-and-add-3 unit converts the magnitude,
// then strips leading zeros and shifts out the digits, with a minus sign first if negative.
// busy stays high while a conversion runs; a new request is taken only while idle.
// No back-pressure; reset (arst_n low) returns the sequencer to idle and drops strobe at once.
// ----------------------------------------------------------------------------
// int64_to_decimal_ascii_unit
// Top level: sequencer, sign handling and the registered character output.
// ----------------------------------------------------------------------------
module int64_to_decimal_ascii_unit import i64da_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [BinWidth-1:0] value,
	output logic                      strobe,
	output logic [CharWidth-1:0]      char_code,
	output logic                      last
);

	i64da_state_t          state_q, state_d;
	logic [CntWidth-1:0]   cnt_q;
	logic [RemWidth-1:0]   rem_q;
	logic                  neg_q;
	logic [BinWidth-1:0]   mag;
	logic [3:0]            top_digit;
	i64da_op_t             op;
	logic                  accept;
	logic                  emit_d;
	logic [CharWidth-1:0]  code_d;
	logic                  last_d;
	logic                  strobe_q;
	logic [CharWidth-1:0]  char_code_q;
	logic                  last_q;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Magnitude by unsigned negation, so the most negative value gives 2^63.
	assign mag = value[BinWidth-1] ? (~value + 64'd1) : value;

	i64da_bcd_unit u_bcd (
		.clk       (clk),
		.op        (op),
		.mag       (mag),
		.top_digit (top_digit)
	);

	// Next state, unit operation and the character to present.
	always_comb begin
		state_d = state_q;
		op      = '0;
		emit_d  = 1'b0;
		code_d  = DigitBase + {2'b00, top_digit};
		last_d  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					op.load = 1'b1;
					state_d = ST_CONVERT;
				end
			end
			ST_CONVERT: begin
				op.dabble = 1'b1;
				if (cnt_q == CntWidth'(BinWidth - 1)) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				// Drop leading zeros but always keep the final digit.
				if (top_digit == 4'd0 && rem_q != RemWidth'(1)) begin
					op.digit_shift = 1'b1;
				end else if (neg_q) begin
					state_d = ST_SIGN;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_SIGN: begin
				emit_d  = 1'b1;
				code_d  = MinusCode;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				emit_d         = 1'b1;
				last_d         = (rem_q == RemWidth'(1));
				op.digit_shift = 1'b1;
				if (rem_q == RemWidth'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer state and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			rem_q    <= '0;
			neg_q    <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit_d;
			if (accept) begin
				cnt_q <= '0;
				rem_q <= RemWidth'(NumDigits);
				neg_q <= value[BinWidth-1];
			end else begin
				if (state_q == ST_CONVERT) begin
					cnt_q <= cnt_q + CntWidth'(1);
				end
				if (op.digit_shift) begin
					rem_q <= rem_q - RemWidth'(1);
				end
			end
		end
	end

	// Output character register.
	always_ff @(posedge clk) begin
		if (emit_d) begin
			char_code_q <= code_d;
			last_q      <= last_d;
		end
	end

	assign strobe    = strobe_q;
	assign char_code = char_code_q;
	assign last      = last_q;

endmodule

// ----- rtl/i64da_bcd_unit.sv -----
// ----------------------------------------------------------------------------
// i64da_bcd_unit
// Shift-and-add-3 unit: converts a binary magnitude to BCD one bit per cycle,
// then shifts the digits out from the most significant end.
// ----------------------------------------------------------------------------
module i64da_bcd_unit import i64da_pkg::*; (
	input  logic                clk,
	input  i64da_op_t           op,
	input  logic [BinWidth-1:0] mag,
	output logic [3:0]          top_digit
);

	logic [BinWidth-1:0] bin_q;
	logic [BcdWidth-1:0] bcd_q;
	logic [BcdWidth-1:0] bcd_adj;

	// Add three to every digit that is five or more, ready for the next shift.
	always_comb begin
		for (int d = 0; d < NumDigits; d++) begin
			if (bcd_q[4*d +: 4] >= 4'd5) begin
				bcd_adj[4*d +: 4] = bcd_q[4*d +: 4] + 4'd3;
			end else begin
				bcd_adj[4*d +: 4] = bcd_q[4*d +: 4];
			end
		end
	end

	// Operand and digit registers; payload only, so no reset is needed.
	always_ff @(posedge clk) begin
		if (op.load) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (op.dabble) begin
			bcd_q <= {bcd_adj[BcdWidth-2:0], bin_q[BinWidth-1]};
			bin_q <= {bin_q[BinWidth-2:0], 1'b0};
		end else if (op.digit_shift) begin
			bcd_q <= {bcd_q[BcdWidth-5:0], 4'd0};
		end
	end

	assign top_digit = bcd_q[BcdWidth-1 -: 4];

endmodule
